[rtl/core/imm_pkg.sv]
package imm_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_DIM       = 8;
    localparam int DEF_ELEMENT_WIDTH = 32;

    // fixed field widths
    localparam int ELEM_W      = 32;
    localparam int PROD_W      = 32;
    localparam int IDX_OUT_W   = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OPC_W       = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PROD_W - 2 * IDX_OUT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_START  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // tag that travels with a partial sum down the cell chain
    typedef struct packed {
        logic                 vld;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 last;
    } t_meta;

endpackage

[rtl/core/integer_matrix_multiply_unit.sv]
// channel   dir  width      contents (lowest bit first)           handshake
// s_axis    in   32 + 2     tdata: element, tuser: opcode           tvalid/tready
// m_axis    out  40 + 1     tdata: product, row, col, pad; tlast     tvalid/tready
// cfg       in   2 + 4      index, data (rows_a, inner_dim, cols_b)  i_cfg_we only
//
// loads are taken back to back while idle
// a start issues one product term per cycle while m_axis is not stalled, as set by
// the single read port of each matrix store; each result passes the registered store
// reads, the cell chain and the output register
// s_axis_tready stays low from the start request until the last result is taken
// a stall on m_axis freezes the whole pipeline; synchronous active-low reset clears
// control only, the matrix stores are not cleared and need no clearing pass
module integer_matrix_multiply_unit import imm_pkg::*; #(
    parameter int MAX_DIM       = DEF_MAX_DIM,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ELEM_W-1:0]      s_axis_tdata,   // [31:0] element
    input  logic [OPC_W-1:0]       s_axis_tuser,   // [1:0] opcode
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] product, [34:32] row, [37:35] col
    output logic                   m_axis_tlast,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = ADDR_W + 1;

    // clamp a size register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    // size registers
    logic [CFG_W-1:0] r_rows_a;
    logic [CFG_W-1:0] r_inner_dim;
    logic [CFG_W-1:0] r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_W'(1);
            r_inner_dim <= CFG_W'(1);
            r_cols_b    <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_nr;
    logic [DIM_W-1:0] w_nk;
    logic [DIM_W-1:0] w_nc;
    logic [CNT_W-1:0] w_cnt_a;
    logic [CNT_W-1:0] w_cnt_b;

    assign w_nr    = eff_dim(r_rows_a);
    assign w_nk    = eff_dim(r_inner_dim);
    assign w_nc    = eff_dim(r_cols_b);
    assign w_cnt_a = CNT_W'(w_nr) * CNT_W'(w_nk);
    assign w_cnt_b = CNT_W'(w_nk) * CNT_W'(w_nc);

    // control state
    t_state r_state;
    t_state n_state;

    logic w_in_acc;
    logic w_adv;
    logic w_wr_a;
    logic w_wr_b;
    logic w_start;
    logic r_out_vld;
    logic r_out_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    // whole pipeline moves unless a finished result is waiting
    assign w_adv         = !r_out_vld || m_axis_tready;

    always_comb begin
        w_wr_a  = 1'b0;
        w_wr_b  = 1'b0;
        w_start = 1'b0;
        if (w_in_acc) begin
            case (t_opcode'(s_axis_tuser))
                OP_LOAD_A: w_wr_a  = 1'b1;
                OP_LOAD_B: w_wr_b  = 1'b1;
                OP_START:  w_start = 1'b1;
                default: ;
            endcase
        end
    end

    // load pointers, wrapping at the element count of each matrix
    logic [ADDR_W-1:0] r_a_ptr;
    logic [ADDR_W-1:0] r_b_ptr;
    logic [ADDR_W-1:0] n_a_ptr;
    logic [ADDR_W-1:0] n_b_ptr;
    logic [CNT_W-1:0]  w_a_ptr_inc;
    logic [CNT_W-1:0]  w_b_ptr_inc;

    assign w_a_ptr_inc = CNT_W'(r_a_ptr) + CNT_W'(1);
    assign w_b_ptr_inc = CNT_W'(r_b_ptr) + CNT_W'(1);

    always_comb begin
        n_a_ptr = r_a_ptr;
        n_b_ptr = r_b_ptr;
        if (w_start) begin
            n_a_ptr = '0;
            n_b_ptr = '0;
        end
        if (w_wr_a) begin
            n_a_ptr = (w_a_ptr_inc >= w_cnt_a) ? '0 : w_a_ptr_inc[ADDR_W-1:0];
        end
        if (w_wr_b) begin
            n_b_ptr = (w_b_ptr_inc >= w_cnt_b) ? '0 : w_b_ptr_inc[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ptr <= '0;
            r_b_ptr <= '0;
        end else begin
            r_a_ptr <= n_a_ptr;
            r_b_ptr <= n_b_ptr;
        end
    end

    // issue counters: row i, column j, inner k, with running store addresses
    logic [IDX_W-1:0]  r_i, r_j, r_k;
    logic [IDX_W-1:0]  n_i, n_j, n_k;
    logic [ADDR_W-1:0] r_a_base, r_a_addr, r_b_addr;
    logic [ADDR_W-1:0] n_a_base, n_a_addr, n_b_addr;
    logic              w_run;
    logic              w_last_i, w_last_j, w_last_k;
    logic              w_last_issue;

    assign w_run        = (r_state == ST_RUN);
    assign w_last_i     = (DIM_W'(r_i) + DIM_W'(1)) == w_nr;
    assign w_last_j     = (DIM_W'(r_j) + DIM_W'(1)) == w_nc;
    assign w_last_k     = (DIM_W'(r_k) + DIM_W'(1)) == w_nk;
    assign w_last_issue = w_run && w_last_i && w_last_j && w_last_k;

    always_comb begin
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_a_base = r_a_base;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        if (w_start) begin
            n_i      = '0;
            n_j      = '0;
            n_k      = '0;
            n_a_base = '0;
            n_a_addr = '0;
            n_b_addr = '0;
        end else if (w_run && w_adv) begin
            if (!w_last_k) begin
                n_k      = r_k + IDX_W'(1);
                n_a_addr = r_a_addr + ADDR_W'(1);
                n_b_addr = r_b_addr + ADDR_W'(w_nc);
            end else if (!w_last_j) begin
                // next column of the same row
                n_k      = '0;
                n_j      = r_j + IDX_W'(1);
                n_a_addr = r_a_base;
                n_b_addr = ADDR_W'(r_j) + ADDR_W'(1);
            end else begin
                // next row
                n_k      = '0;
                n_j      = '0;
                n_i      = r_i + IDX_W'(1);
                n_a_base = r_a_base + ADDR_W'(w_nk);
                n_a_addr = r_a_base + ADDR_W'(w_nk);
                n_b_addr = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else begin
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_a_base <= n_a_base;
            r_a_addr <= n_a_addr;
            r_b_addr <= n_b_addr;
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_adv && w_last_issue) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                // done once the flagged result is taken
                if (r_out_vld && m_axis_tready && r_out_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // matrix stores
    logic [ELEMENT_WIDTH-1:0] w_rd_a;
    logic [ELEMENT_WIDTH-1:0] w_rd_b;

    imm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEMENT_WIDTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_wr_a),
        .i_waddr (r_a_ptr),
        .i_wdata (s_axis_tdata[ELEMENT_WIDTH-1:0]),
        .i_re    (w_adv),
        .i_raddr (r_a_addr),
        .o_rdata (w_rd_a)
    );

    imm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEMENT_WIDTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_wr_b),
        .i_waddr (r_b_ptr),
        .i_wdata (s_axis_tdata[ELEMENT_WIDTH-1:0]),
        .i_re    (w_adv),
        .i_raddr (r_b_addr),
        .o_rdata (w_rd_b)
    );

    // broadcast stage, aligned with the registered store reads
    logic [PROD_W-1:0] w_bc_a;
    logic [PROD_W-1:0] w_bc_b;
    logic              r_bc_vld;
    logic [IDX_W-1:0]  r_bc_k;
    t_meta             w_iss_meta;
    t_meta             r_bc_meta;
    t_meta             r_meta0;

    assign w_bc_a = PROD_W'(signed'(w_rd_a));
    assign w_bc_b = PROD_W'(signed'(w_rd_b));

    // a result tag is born with the first inner term of each element
    always_comb begin
        w_iss_meta.vld  = w_run && (r_k == '0);
        w_iss_meta.row  = IDX_OUT_W'(r_i);
        w_iss_meta.col  = IDX_OUT_W'(r_j);
        w_iss_meta.last = w_last_i && w_last_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc_vld  <= 1'b0;
            r_bc_meta <= '0;
            r_meta0   <= '0;
        end else if (w_adv) begin
            r_bc_vld  <= w_run;
            r_bc_k    <= r_k;
            r_bc_meta <= w_iss_meta;
            // registered once more so the tag meets cell 0 together with its product
            r_meta0   <= r_bc_meta;
        end
    end

    // chain of cells: cell k adds term k to the sum passing by
    logic [PROD_W-1:0] w_psum [MAX_DIM+1];
    t_meta             w_meta [MAX_DIM+1];

    assign w_psum[0] = '0;
    assign w_meta[0] = r_meta0;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        imm_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_adv),
            .i_bc_vld (r_bc_vld),
            .i_bc_k   (r_bc_k),
            .i_bc_a   (w_bc_a),
            .i_bc_b   (w_bc_b),
            .i_psum   (w_psum[g]),
            .i_meta   (w_meta[g]),
            .o_psum   (w_psum[g+1]),
            .o_meta   (w_meta[g+1])
        );
    end

    // output register
    logic [PROD_W-1:0]    r_out_prod;
    logic [IDX_OUT_W-1:0] r_out_row;
    logic [IDX_OUT_W-1:0] r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld  <= w_meta[MAX_DIM].vld;
            r_out_prod <= w_psum[MAX_DIM];
            r_out_row  <= w_meta[MAX_DIM].row;
            r_out_col  <= w_meta[MAX_DIM].col;
            r_out_last <= w_meta[MAX_DIM].last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out_col, r_out_row, r_out_prod};
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/core/imm_store.sv]
module imm_store import imm_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_DIM * DEF_MAX_DIM,
    parameter int ADDR_W = $clog2(DEF_MAX_DIM * DEF_MAX_DIM),
    parameter int DATA_W = DEF_ELEMENT_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/imm_cell.sv]
module imm_cell import imm_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = $clog2(DEF_MAX_DIM)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_bc_vld,
    input  logic [IDX_W-1:0]  i_bc_k,
    input  logic [PROD_W-1:0] i_bc_a,
    input  logic [PROD_W-1:0] i_bc_b,
    input  logic [PROD_W-1:0] i_psum,
    input  t_meta             i_meta,
    output logic [PROD_W-1:0] o_psum,
    output t_meta             o_meta
);

    localparam logic [IDX_W-1:0] MY_K = IDX_W'(CELL_IDX);

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_psum;
    t_meta             r_meta;

    // product only for the inner index owned by this cell, zero otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (i_bc_vld && (i_bc_k == MY_K)) ? i_bc_a * i_bc_b : '0;
            r_psum <= i_psum + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= i_meta;
        end
    end

    assign o_psum = r_psum;
    assign o_meta = r_meta;

endmodule

[rtl/core/imm_checker.sv]
module imm_checker import imm_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OPC_W-1:0]       s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // no new request while results are pending
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result waits");

    // an accepted start closes the input
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_START) |=> !s_axis_tready)
        else $error("input ready right after a start");

    // taking the last result reopens the input
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not ready after the last result");

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (.*);

[tb/tb_top.sv]
module tb_top;
    import imm_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_DIM * DEF_MAX_DIM;
    localparam int RANDOM_ITEMS  = 30;
    localparam int SETTLE_CYCLES = DEF_MAX_DIM + 12;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 20000;

    // codes the port width allows but the block does not define
    localparam logic [OPC_W-1:0]     OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PROD_W-1:0]    product;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 last;
    } t_product_elem;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [ELEM_W-1:0]      s_axis_tdata  = '0;   // [31:0] element
    logic [OPC_W-1:0]       s_axis_tuser  = '0;   // [1:0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [31:0] product, [34:32] row, [37:35] col
    logic                   m_axis_tlast;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;

    // shadow copy of the block: sizes, both stores, load pointers
    logic [CFG_W-1:0]  size_reg [3] = '{4'd1, 4'd1, 4'd1};
    logic [ELEM_W-1:0] shadow_mem [2][STORE_DEPTH];
    bit [STORE_DEPTH-1:0] shadow_written [2] = '{'0, '0};
    int load_ptr [2] = '{0, 0};

    t_product_elem expected_products [$];
    int fail_count = 0;
    int items_done = 0;
    int hold_req   = 0;
    bit rush       = 1'b0;

    integer_matrix_multiply_unit #(
        .MAX_DIM       (DEF_MAX_DIM),
        .ELEMENT_WIDTH (DEF_ELEMENT_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void record_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // size register as the block uses it: zero acts as one, above max clamps
    function automatic int eff_size(logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
        return int'(raw);
    endfunction

    // element count of A (0) or B (1) under the current sizes
    function automatic int entry_count(int which);
        if (which == 0) return eff_size(size_reg[CFG_ROWS_A]) * eff_size(size_reg[CFG_INNER_DIM]);
        return eff_size(size_reg[CFG_INNER_DIM]) * eff_size(size_reg[CFG_COLS_B]);
    endfunction

    // every entry a multiply would read has been written at some point
    function automatic bit loaded(int which);
        for (int e = 0; e < entry_count(which); e++) begin
            if (!shadow_written[which][e]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [ELEM_W-1:0] narrow(logic [ELEM_W-1:0] raw);
        logic signed [ELEM_W-1:0] t;
        t = raw << (ELEM_W - DEF_ELEMENT_WIDTH);
        return t >>> (ELEM_W - DEF_ELEMENT_WIDTH);
    endfunction

    function automatic void shadow_load(int which, logic [ELEM_W-1:0] raw);
        int p;
        p = load_ptr[which];
        shadow_mem[which][p] = narrow(raw);
        shadow_written[which][p] = 1'b1;
        p++;
        // pointer wraps at the element count, which may have shrunk below it
        if (p >= entry_count(which) || p >= STORE_DEPTH) p = 0;
        load_ptr[which] = p;
    endfunction

    // all product elements in row-major order, sums wrap at 32 bits; load pointers go back to zero
    function automatic void predict_products();
        int nr, nk, nc;
        logic [PROD_W-1:0] acc;
        t_product_elem e;
        nr = eff_size(size_reg[CFG_ROWS_A]);
        nk = eff_size(size_reg[CFG_INNER_DIM]);
        nc = eff_size(size_reg[CFG_COLS_B]);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = '0;
                for (int k = 0; k < nk; k++) begin
                    acc = acc + shadow_mem[0][(i * nk + k) % STORE_DEPTH]
                              * shadow_mem[1][(k * nc + j) % STORE_DEPTH];
                end
                e.product = acc;
                e.row     = IDX_OUT_W'(i);
                e.col     = IDX_OUT_W'(j);
                e.last    = (i == nr - 1) && (j == nc - 1);
                expected_products.push_back(e);
            end
        end
        load_ptr[0] = 0;
        load_ptr[1] = 0;
    endfunction

    function automatic logic [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            4: return 32'($urandom_range(0, 31)) - 32'd16;
            default: return $urandom();
        endcase
    endfunction

    function automatic void check_product();
        t_product_elem got, want;
        got.product = m_axis_tdata[PROD_W-1:0];
        got.row     = m_axis_tdata[PROD_W +: IDX_OUT_W];
        got.col     = m_axis_tdata[PROD_W + IDX_OUT_W +: IDX_OUT_W];
        got.last    = m_axis_tlast;
        if (expected_products.size() == 0) begin
            record_failure($sformatf("unexpected product %h row %0d col %0d last %0b",
                                     got.product, got.row, got.col, got.last));
            return;
        end
        want = expected_products.pop_front();
        if (got.product !== want.product || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
            record_failure($sformatf(
                "mismatch: exp %h r%0d c%0d l%0b, got %h r%0d c%0d l%0b",
                want.product, want.row, want.col, want.last,
                got.product, got.row, got.col, got.last));
        end
    endfunction

    // receiver: random hold-off per product, or one long hold on request
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                m_axis_tready = 1'b0;
                repeat (hold_req) @(negedge i_clk);
                hold_req = 0;
            end else begin
                gap = rush ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    m_axis_tready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                m_axis_tready = 1'b1;
                @(posedge i_clk);
                while (!m_axis_tvalid && hold_req == 0) @(posedge i_clk);
                if (m_axis_tvalid) check_product();
            end
        end
    end

    // one request on the slave side, with a random gap in front
    task automatic send_item(logic [OPC_W-1:0] op, logic [ELEM_W-1:0] elem);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = elem;
        s_axis_tuser  = op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (op)
            OP_LOAD_A: shadow_load(0, elem);
            OP_LOAD_B: shadow_load(1, elem);
            OP_START:  predict_products();
            default:   ;
        endcase
        if (op != OP_UNUSED) items_done++;
    endtask

    // sender stops and waits until every product is out, then a settling pause
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx != CFG_UNUSED) size_reg[idx] = data;
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c,
                             bit poke_unused);
        wait_idle();
        write_reg(CFG_ROWS_A, r);
        write_reg(CFG_INNER_DIM, k);
        write_reg(CFG_COLS_B, c);
        if (poke_unused) write_reg(CFG_UNUSED, 4'hf);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // full loads of A and B interleaved at random, then a start
    task automatic run_multiply(int hold);
        int na, nb;
        na = entry_count(0);
        nb = entry_count(1);
        while (na + nb > 0) begin
            if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1)) begin
                send_item(OP_LOAD_A, rand_element());
                na--;
            end else begin
                send_item(OP_LOAD_B, rand_element());
                nb--;
            end
        end
        // a pointer left beyond the count needs one more load to cover everything
        while (!loaded(0)) send_item(OP_LOAD_A, rand_element());
        while (!loaded(1)) send_item(OP_LOAD_B, rand_element());
        if (hold > 0) hold_req = hold;
        send_item(OP_START, rand_element());
    endtask

    // 1x1x1 at reset sizes: sign extremes, wrap of the product, ignored opcode
    task automatic t_extremes();
        send_item(OP_LOAD_A, 32'h8000_0000);
        send_item(OP_LOAD_B, 32'h8000_0000);
        send_item(OP_START, '1);
        send_item(OP_LOAD_A, '1);
        send_item(OP_LOAD_B, 32'h7fff_ffff);
        send_item(OP_UNUSED, 32'h5a5a_a5a5);
        send_item(OP_START, '0);
        send_item(OP_LOAD_A, 32'h7fff_ffff);
        send_item(OP_LOAD_B, 32'h7fff_ffff);
        send_item(OP_START, 32'h0000_ffff);
    endtask

    // zero and oversized registers clamp, unused register index ignored, 64 products
    task automatic t_size_clamp();
        set_sizes(4'd15, 4'd0, 4'd9, 1'b1);
        run_multiply(0);
    endtask

    // long receiver stall fills the pipeline; loads behind the start must wait
    task automatic t_backpressure();
        set_sizes(4'd2, 4'd3, 4'd2, 1'b0);
        run_multiply(LONG_HOLD);
        run_multiply(0);
        wait_idle();
    endtask

    task automatic t_back_to_back();
        set_sizes(4'd3, 4'd2, 4'd2, 1'b0);
        rush = 1'b1;
        repeat (2) run_multiply(0);
        wait_idle();
        rush = 1'b0;
    endtask

    // full A store and every cell of the chain
    task automatic t_max_size();
        set_sizes(4'd8, 4'd8, 4'd1, 1'b0);
        run_multiply(0);
    endtask

    task automatic t_random();
        int base, n, which;
        logic [CFG_W-1:0] sz [3];
        logic [OPC_W-1:0] op;
        base = items_done;
        while (items_done - base < RANDOM_ITEMS) begin
            // mostly small sizes, sometimes one register at an extreme or a larger size
            n = $urandom_range(0, 9);
            if (n < 7) begin
                foreach (sz[d]) sz[d] = CFG_W'($urandom_range(1, 3));
            end else if (n < 9) begin
                foreach (sz[d]) sz[d] = CFG_W'($urandom_range(1, 2));
                case ($urandom_range(0, 2))
                    0: sz[$urandom_range(0, 2)] = 4'd0;
                    1: sz[$urandom_range(0, 2)] = CFG_W'($urandom_range(9, 15));
                    default: sz[$urandom_range(0, 2)] = CFG_W'($urandom_range(4, 7));
                endcase
            end else begin
                foreach (sz[d]) sz[d] = CFG_W'($urandom_range(4, 5));
            end
            set_sizes(sz[0], sz[1], sz[2], 1'b0);
            rush = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 4)) begin
                if (items_done - base >= RANDOM_ITEMS) break;
                n = $urandom_range(0, 9);
                if (n < 7) begin
                    run_multiply(0);
                end else if (n == 7) begin
                    // noise: any opcode, a start only when the stores are covered
                    repeat ($urandom_range(1, 4)) begin
                        op = OPC_W'($urandom_range(0, 3));
                        if (op == OP_START && !(loaded(0) && loaded(1))) op = OP_UNUSED;
                        send_item(op, rand_element());
                    end
                end else if (n == 8) begin
                    // broken sequence: partial load, then a start on stale entries if covered, else a full multiply
                    which = $urandom_range(0, 1);
                    repeat ($urandom_range(1, entry_count(which)))
                        send_item(which ? OP_LOAD_B : OP_LOAD_A, rand_element());
                    if (loaded(0) && loaded(1)) send_item(OP_START, rand_element());
                    else run_multiply(0);
                end else begin
                    // overfull load of A wraps the pointer
                    repeat (entry_count(0) + $urandom_range(1, 3))
                        send_item(OP_LOAD_A, rand_element());
                    run_multiply(0);
                end
            end
            wait_idle();
            rush = 1'b0;
        end
    endtask

    initial begin
        int spins;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        t_extremes();
        t_size_clamp();
        t_backpressure();
        t_back_to_back();
        t_max_size();
        t_random();

        // drain what is still in flight, then watch for strays
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        spins = 0;
        while (expected_products.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_products.size() != 0)
            record_failure($sformatf("%0d products never arrived", expected_products.size()));

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
